// ----- hdl/dbds_pkg.sv -----
`default_nettype none
package dbds_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int SECTOR_W   = 48;
    localparam int COUNT_W    = 16;
    localparam int DEADLINE_W = 32;
    localparam int STATUS_W   = 3;
    localparam int EST_W      = 33;
    localparam int BUDGET_W   = 40;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QEMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BEMPTY     = 3'd4;

    // Register indexes.
    localparam logic [2:0] REG_SEEK     = 3'd0;
    localparam logic [2:0] REG_ROTATION = 3'd1;
    localparam logic [2:0] REG_TRANSFER = 3'd2;
    localparam logic [2:0] REG_SLICE    = 3'd3;
    localparam logic [2:0] REG_TRACK    = 3'd4;
    localparam logic [2:0] REG_DIVISOR  = 3'd5;

    localparam logic [19:0] SEEK_RST     = 20'd19000;
    localparam logic [19:0] ROTATION_RST = 20'd11111;
    localparam logic [15:0] TRANSFER_RST = 16'd5;
    localparam logic [23:0] SLICE_RST    = 24'd350000;
    localparam logic [23:0] TRACK_RST    = 24'd50000;
    localparam logic [15:0] DIVISOR_RST  = 16'd1000;

    typedef struct packed {
        logic [19:0] seek;
        logic [19:0] rotation;
        logic [15:0] transfer;
        logic [23:0] slice;
        logic [23:0] track;
        logic [15:0] divisor;
    } cfg_t;

    typedef struct packed {
        logic [SECTOR_W-1:0]   sector;
        logic [COUNT_W-1:0]    count;
        logic [DEADLINE_W-1:0] deadline;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/dbds_in_if.sv -----
`default_nettype none
interface dbds_in_if;
    import dbds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [SECTOR_W-1:0]   start_sector;
    logic [COUNT_W-1:0]    sector_count;
    logic [DEADLINE_W-1:0] deadline;

    modport source (output valid, action, start_sector, sector_count, deadline,
                    input ready);
    modport sink (input valid, action, start_sector, sector_count, deadline,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/dbds_out_if.sv -----
`default_nettype none
interface dbds_out_if;
    import dbds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SECTOR_W-1:0]   out_sector;
    logic [COUNT_W-1:0]    out_count;
    logic [DEADLINE_W-1:0] out_deadline;
    logic                  last;

    modport source (output valid, status, out_sector, out_count, out_deadline, last,
                    input ready);
    modport sink (input valid, status, out_sector, out_count, out_deadline, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/dbds_cfg.sv -----
`default_nettype none
module dbds_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dbds_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dbds_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dbds_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output dbds_pkg::cfg_t                       cfg
);
    import dbds_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seek     <= SEEK_RST;
            cfg_reg.rotation <= ROTATION_RST;
            cfg_reg.transfer <= TRANSFER_RST;
            cfg_reg.slice    <= SLICE_RST;
            cfg_reg.track    <= TRACK_RST;
            cfg_reg.divisor  <= DIVISOR_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_SEEK:     cfg_reg.seek     <= pwdata[19:0];
                REG_ROTATION: cfg_reg.rotation <= pwdata[19:0];
                REG_TRANSFER: cfg_reg.transfer <= pwdata[15:0];
                REG_SLICE:    cfg_reg.slice    <= pwdata[23:0];
                REG_TRACK:    cfg_reg.track    <= pwdata[23:0];
                REG_DIVISOR:  cfg_reg.divisor  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SEEK:     prdata = {12'd0, cfg_reg.seek};
            REG_ROTATION: prdata = {12'd0, cfg_reg.rotation};
            REG_TRANSFER: prdata = {16'd0, cfg_reg.transfer};
            REG_SLICE:    prdata = {8'd0, cfg_reg.slice};
            REG_TRACK:    prdata = {8'd0, cfg_reg.track};
            REG_DIVISOR:  prdata = {16'd0, cfg_reg.divisor};
            default:      prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/dbds_div.sv -----
`default_nettype none
module dbds_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [dbds_pkg::DEADLINE_W-1:0] dividend,
    input  wire logic [15:0]                     divisor,
    output logic                                 busy,
    output logic      [dbds_pkg::DEADLINE_W-1:0] quotient
);
    import dbds_pkg::*;

    // Restoring division, one quotient bit per cycle.
    logic [DEADLINE_W-1:0] work_reg, work_next;
    logic [15:0]           rem_reg, rem_next;
    logic [15:0]           dvs_reg, dvs_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [16:0]           trial;

    assign busy     = busy_reg;
    assign quotient = work_reg;
    assign trial    = {rem_reg, work_reg[DEADLINE_W-1]};

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == 16'd0) ? 16'd1 : divisor;
            cnt_next  = 6'(DEADLINE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = 16'(trial - {1'b0, dvs_reg});
                work_next = {work_reg[DEADLINE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[15:0];
                work_next = {work_reg[DEADLINE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end
endmodule
`default_nettype wire

// ----- hdl/deadline_batch_disk_scheduler_top.sv -----
`default_nettype none
// An add reads and compares each queued entry that it moves past; a dispatch
// takes each request through the queue read, the divider that scales the deadline and
// the budget check, then reads and compares each batch entry passed in the sector sort,
// then reads and emits each result. One transaction is worked on at a time.
// Reset: rst_n clears the queue fill, the sequencer and the output valid at once,
// and loads the configuration registers with their default values.
module deadline_batch_disk_scheduler_top #(
    parameter int QUEUE_DEPTH = dbds_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dbds_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dbds_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dbds_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    dbds_in_if.sink                              in_ch,
    dbds_out_if.source                           out_ch
);
    import dbds_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // One-hot sequencer states.
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_INS_RD   = 11'b00000000010,
        S_INS_CMP  = 11'b00000000100,
        S_DSP_CHK  = 11'b00000001000,
        S_DSP_RD   = 11'b00000010000,
        S_DSP_DIV  = 11'b00000100000,
        S_DSP_EVAL = 11'b00001000000,
        S_BAT_RD   = 11'b00010000000,
        S_BAT_CMP  = 11'b00100000000,
        S_EMIT_RD  = 11'b01000000000,
        S_EMIT_LD  = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        entry_t              data;
        logic                last;
    } result_t;

    cfg_t cfg;

    dbds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           taken_reg, taken_next;
    logic signed [BUDGET_W-1:0] budget_reg, budget_next;
    logic [EST_W-1:0]           est_reg, est_next;
    entry_t                     item_reg, item_next;
    logic [STATUS_W-1:0]        stat_reg, stat_next;
    logic                       resp_reg, resp_next;
    result_t                    out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    // The request queue is a ring; logical slot 0 is the head.
    entry_t q_mem [QUEUE_DEPTH];
    entry_t q_rd_reg;
    logic   q_we, q_re;
    logic [IDX_W-1:0] q_wa, q_ra;
    entry_t q_wd;

    // Working store of one batch, kept sorted by start sector.
    entry_t b_mem [QUEUE_DEPTH];
    entry_t b_rd_reg;
    logic   b_we, b_re;
    logic [IDX_W-1:0] b_wa, b_ra;
    entry_t b_wd;

    logic                  div_start, div_busy;
    logic [DEADLINE_W-1:0] div_quot;

    dbds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_rd_reg.deadline),
        .divisor  (cfg.divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] h,
                                                   input logic [CNT_W-1:0] l);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // True when a new deadline ranks strictly ahead of a queued one; no deadline
    // ranks behind every real deadline.
    function automatic logic ranks_ahead(input logic [DEADLINE_W-1:0] a,
                                         input logic [DEADLINE_W-1:0] b);
        logic r;
        if (a == '0)
        begin
            r = 1'b0;
        end
        else if (b == '0)
        begin
            r = 1'b1;
        end
        else
        begin
            r = a < b;
        end
        return r;
    endfunction

    logic                       slot_free;
    logic [31:0]                xfer_prod;
    logic signed [BUDGET_W-1:0] scaled_s, budget_cap, est_s;

    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign xfer_prod  = cfg.transfer * q_rd_reg.count;
    assign scaled_s   = $signed(BUDGET_W'(div_quot));
    assign est_s      = $signed(BUDGET_W'(est_reg));
    assign budget_cap = (div_quot != '0 && scaled_s < budget_reg) ? scaled_s : budget_reg;

    assign in_ch.ready         = (state_reg == S_IDLE) && !resp_reg;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_reg.status;
    assign out_ch.out_sector   = out_reg.data.sector;
    assign out_ch.out_count    = out_reg.data.count;
    assign out_ch.out_deadline = out_reg.data.deadline;
    assign out_ch.last         = out_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        taken_next     = taken_reg;
        budget_next    = budget_reg;
        est_next       = est_reg;
        item_next      = item_reg;
        stat_next      = stat_reg;
        resp_next      = resp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        q_we           = 1'b0;
        q_re           = 1'b0;
        q_wa           = ring_addr(head_reg, idx_reg);
        q_ra           = ring_addr(head_reg, idx_reg - CNT_W'(1));
        q_wd           = item_reg;
        b_we           = 1'b0;
        b_re           = 1'b0;
        b_wa           = idx_reg[IDX_W-1:0];
        b_ra           = idx_reg[IDX_W-1:0] - IDX_W'(1);
        b_wd           = item_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (resp_reg)
                begin
                    // A single status result waits here for a free output slot.
                    if (slot_free)
                    begin
                        out_next       = '{status: stat_reg, data: '0, last: 1'b1};
                        out_valid_next = 1'b1;
                        resp_next      = 1'b0;
                    end
                end
                else if (in_ch.valid)
                begin
                    item_next = '{sector: in_ch.start_sector, count: in_ch.sector_count,
                                  deadline: in_ch.deadline};
                    if (!in_ch.action)
                    begin
                        if (fill_reg == DEPTH_C)
                        begin
                            stat_next = ST_FULL;
                            resp_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = fill_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        stat_next = ST_QEMPTY;
                        resp_next = 1'b1;
                    end
                    else
                    begin
                        budget_next = $signed(BUDGET_W'(cfg.slice))
                                    - $signed(BUDGET_W'(cfg.track));
                        taken_next  = '0;
                        state_next  = S_DSP_CHK;
                    end
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    q_we       = 1'b1;
                    fill_next  = fill_reg + CNT_W'(1);
                    stat_next  = ST_ADDED;
                    resp_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    q_re       = 1'b1;
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                q_we = 1'b1;
                if (ranks_ahead(item_reg.deadline, q_rd_reg.deadline))
                begin
                    q_wd       = q_rd_reg;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    fill_next  = fill_reg + CNT_W'(1);
                    stat_next  = ST_ADDED;
                    resp_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DSP_CHK:
            begin
                if (fill_reg == '0 || budget_reg <= 0)
                begin
                    idx_next = '0;
                    if (taken_reg == '0)
                    begin
                        stat_next  = ST_BEMPTY;
                        resp_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    q_re       = 1'b1;
                    q_ra       = head_reg;
                    state_next = S_DSP_RD;
                end
            end

            S_DSP_RD:
            begin
                item_next  = q_rd_reg;
                est_next   = EST_W'(cfg.seek) + EST_W'(cfg.rotation) + EST_W'(xfer_prod);
                div_start  = 1'b1;
                state_next = S_DSP_DIV;
            end

            S_DSP_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DSP_EVAL;
                end
            end

            S_DSP_EVAL:
            begin
                if (est_s > budget_cap && div_quot == '0)
                begin
                    idx_next = '0;
                    if (taken_reg == '0)
                    begin
                        stat_next  = ST_BEMPTY;
                        resp_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    budget_next = budget_cap - est_s;
                    head_next   = ring_addr(head_reg, CNT_W'(1));
                    fill_next   = fill_reg - CNT_W'(1);
                    idx_next    = taken_reg;
                    state_next  = S_BAT_RD;
                end
            end

            S_BAT_RD:
            begin
                if (idx_reg == '0)
                begin
                    b_we       = 1'b1;
                    taken_next = taken_reg + CNT_W'(1);
                    state_next = S_DSP_CHK;
                end
                else
                begin
                    b_re       = 1'b1;
                    state_next = S_BAT_CMP;
                end
            end

            S_BAT_CMP:
            begin
                b_we = 1'b1;
                if (item_reg.sector < b_rd_reg.sector)
                begin
                    b_wd       = b_rd_reg;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_BAT_RD;
                end
                else
                begin
                    taken_next = taken_reg + CNT_W'(1);
                    state_next = S_DSP_CHK;
                end
            end

            S_EMIT_RD:
            begin
                b_re       = 1'b1;
                b_ra       = idx_reg[IDX_W-1:0];
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_next = '{status: ST_DISPATCHED, data: b_rd_reg,
                                 last: (idx_reg + CNT_W'(1)) == taken_reg};
                    out_valid_next = 1'b1;
                    if ((idx_reg + CNT_W'(1)) == taken_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            resp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            resp_reg      <= resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        taken_reg  <= taken_next;
        budget_reg <= budget_next;
        est_reg    <= est_next;
        item_reg   <= item_next;
        stat_reg   <= stat_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= q_mem[q_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_wa] <= b_wd;
        end
        if (b_re)
        begin
            b_rd_reg <= b_mem[b_ra];
        end
    end

    // The queue can never hold more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("queue fill above depth");

    // Every status other than a dispatched request closes its transaction.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_DISPATCHED |-> out_ch.last)
        else $error("status result without last");

    // A refused add leaves the queue fill unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && !in_ch.action && fill_reg == DEPTH_C
        |=> fill_reg == DEPTH_C)
        else $error("full queue changed on refused add");
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
// Self-checking bench for the deadline batch disk scheduler.
// A directed table comes first, then random traffic under several register settings.
// A predictor keeps its own copy of the deadline queue and the configuration.
// Every accepted output transaction is compared with the oldest predicted one.
module tb_top;
    import dbds_pkg::*;

    localparam int DEPTH    = QUEUE_DEPTH_DEF;
    localparam int WD_LIMIT = 40000;

    typedef struct {
        logic                  action;
        logic [SECTOR_W-1:0]   sector;
        logic [COUNT_W-1:0]    count;
        logic [DEADLINE_W-1:0] deadline;
        bit                    typed;       // expected status typed into the table
        logic [STATUS_W-1:0]   typed_status;
    } req_t;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [SECTOR_W-1:0]   sector;
        logic [COUNT_W-1:0]    count;
        logic [DEADLINE_W-1:0] deadline;
        logic                  last;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    dbds_in_if  in_ch();
    dbds_out_if out_ch();

    deadline_batch_disk_scheduler_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #4 clk = ~clk;

    // Predictor state: configuration, deadline-ordered queue, and batch store.
    cfg_t   sched_cfg;
    entry_t pend_q[DEPTH];
    int     pend_fill;
    entry_t batch[DEPTH];

    resp_t  expected_resp[$];
    int     errors = 0;
    int     n_adds = 0, n_dispatches = 0, n_results = 0, n_batches = 0;
    bit     steady = 1'b0;   // when set, neither side idles
    int     quiet = 0;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic void push_status(logic [STATUS_W-1:0] st);
        resp_t r;
        r = '{status: st, sector: '0, count: '0, deadline: '0, last: 1'b1};
        expected_resp.push_back(r);
    endfunction

    function automatic longint deadline_rank(logic [DEADLINE_W-1:0] d);
        return (d == 0) ? 64'h1_0000_0000 : longint'(64'(d));
    endfunction

    function automatic void predict_add(req_t r);
        int pos;
        if (pend_fill >= DEPTH) begin
            push_status(ST_FULL);
            return;
        end
        pos = pend_fill;
        for (int i = 0; i < pend_fill; i++)
            if (deadline_rank(r.deadline) < deadline_rank(pend_q[i].deadline)) begin
                pos = i;
                break;
            end
        for (int i = pend_fill; i > pos; i--)
            pend_q[i] = pend_q[i-1];
        pend_q[pos] = '{sector: r.sector, count: r.count, deadline: r.deadline};
        pend_fill++;
        push_status(ST_ADDED);
    endfunction

    // Fill one batch from the queue head under the time budget, then emit it sorted.
    function automatic void predict_dispatch();
        longint budget, scaled, est;
        longint unsigned div;
        entry_t head;
        int taken, pos;
        resp_t r;
        if (pend_fill == 0) begin
            push_status(ST_QEMPTY);
            return;
        end
        div = (sched_cfg.divisor == 0) ? 1 : 64'(sched_cfg.divisor);
        budget = longint'(64'(sched_cfg.slice)) - longint'(64'(sched_cfg.track));
        taken = 0;
        while (pend_fill > 0 && budget > 0) begin
            head = pend_q[0];
            scaled = longint'(64'(head.deadline) / div);
            est = longint'(64'(sched_cfg.seek)) + longint'(64'(sched_cfg.rotation))
                + longint'(64'(sched_cfg.transfer)) * longint'(64'(head.count));
            if (scaled != 0 && scaled < budget)
                budget = scaled;
            if (est > budget && scaled == 0)
                break;
            budget -= est;
            for (int i = 1; i < pend_fill; i++)
                pend_q[i-1] = pend_q[i];
            pend_fill--;
            pos = taken;
            for (int i = 0; i < taken; i++)
                if (head.sector < batch[i].sector) begin
                    pos = i;
                    break;
                end
            for (int i = taken; i > pos; i--)
                batch[i] = batch[i-1];
            batch[pos] = head;
            taken++;
        end
        if (taken == 0) begin
            push_status(ST_BEMPTY);
            return;
        end
        n_batches++;
        for (int k = 0; k < taken; k++) begin
            r = '{status: ST_DISPATCHED, sector: batch[k].sector, count: batch[k].count,
                  deadline: batch[k].deadline, last: (k == taken - 1)};
            expected_resp.push_back(r);
        end
    endfunction

    // Mirror of a register write; bits above the register width fall away.
    function automatic void predict_config(int idx, logic [31:0] val);
        case (idx)
            REG_SEEK:     sched_cfg.seek = val[19:0];
            REG_ROTATION: sched_cfg.rotation = val[19:0];
            REG_TRANSFER: sched_cfg.transfer = val[15:0];
            REG_SLICE:    sched_cfg.slice = val[23:0];
            REG_TRACK:    sched_cfg.track = val[23:0];
            REG_DIVISOR:  sched_cfg.divisor = val[15:0];
            default: ;
        endcase
    endfunction

    task automatic reg_write(int idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * idx);
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        predict_config(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Present one request, idling first at random, and predict it once it is accepted.
    task automatic send(req_t r);
        resp_t first;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 36) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= r.action;
        in_ch.start_sector <= r.sector;
        in_ch.sector_count <= r.count;
        in_ch.deadline <= r.deadline;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (r.action) begin
            n_dispatches++;
            predict_dispatch();
        end else begin
            n_adds++;
            predict_add(r);
        end
        if (r.typed) begin
            first = expected_resp[$];
            if (first.status != r.typed_status)
                report("table status", first.status, r.typed_status);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_resp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random request: an add or, less often, a dispatch, with varied deadlines and sizes.
    function automatic req_t random_req();
        req_t r;
        int pick;
        r.typed = 1'b0;
        r.typed_status = ST_ADDED;
        r.action = ($urandom_range(99) < 42);
        r.sector = SECTOR_W'({$urandom, $urandom});
        if ($urandom_range(3) == 0)
            r.sector = SECTOR_W'($urandom_range(63));
        pick = $urandom_range(9);
        r.count = (pick == 0) ? 16'hFFFF : (pick < 7) ? COUNT_W'($urandom_range(255))
                                                     : COUNT_W'($urandom);
        pick = $urandom_range(7);
        case (pick)
            0, 1: r.deadline = '0;
            2:    r.deadline = DEADLINE_W'($urandom_range(999));
            3:    r.deadline = $urandom;
            default: r.deadline = DEADLINE_W'($urandom_range(400_000_000));
        endcase
        return r;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            send(random_req());
    endtask

    task automatic set_all(logic [31:0] s, logic [31:0] rt, logic [31:0] x,
                           logic [31:0] sl, logic [31:0] tr, logic [31:0] dv);
        reg_write(REG_SEEK, s);
        reg_write(REG_ROTATION, rt);
        reg_write(REG_TRANSFER, x);
        reg_write(REG_SLICE, sl);
        reg_write(REG_TRACK, tr);
        reg_write(REG_DIVISOR, dv);
    endtask

    // The sink stalls at random, except during the steady stretch.
    always @(negedge clk)
        out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 36);

    // Compare each accepted output transaction with the oldest prediction.
    always @(posedge clk) begin
        resp_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_resp.size() == 0) begin
                errors++;
                $display("%0t unexpected output transaction, status %0d",
                         $realtime, out_ch.status);
            end else begin
                want = expected_resp.pop_front();
                if (out_ch.status !== want.status)
                    report("status", out_ch.status, want.status);
                if (out_ch.out_sector !== want.sector)
                    report("out_sector", out_ch.out_sector, want.sector);
                if (out_ch.out_count !== want.count)
                    report("out_count", out_ch.out_count, want.count);
                if (out_ch.out_deadline !== want.deadline)
                    report("out_deadline", out_ch.out_deadline, want.deadline);
                if (out_ch.last !== want.last)
                    report("last", out_ch.last, want.last);
            end
        end
    end

    // Watchdog: any transaction or register access counts as progress.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("watchdog expired with %0d transactions outstanding",
                     expected_resp.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    req_t table_rows[$];

    function automatic req_t row(logic act, logic [SECTOR_W-1:0] s, logic [COUNT_W-1:0] c,
                                 logic [DEADLINE_W-1:0] d, bit typed,
                                 logic [STATUS_W-1:0] st);
        req_t r;
        r = '{action: act, sector: s, count: c, deadline: d, typed: typed, typed_status: st};
        return r;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.start_sector = '0;
        in_ch.sector_count = '0;
        in_ch.deadline = '0;
        out_ch.ready = 1'b0;
        sched_cfg = '{seek: SEEK_RST, rotation: ROTATION_RST, transfer: TRANSFER_RST,
                      slice: SLICE_RST, track: TRACK_RST, divisor: DIVISOR_RST};
        pend_fill = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. A dispatch on the empty queue, sixteen adds that cover the
        // field extremes, the no-deadline and small-deadline cases and equal deadlines,
        // one add into the full queue, then dispatches that take batches from it.
        table_rows.push_back(row(1, 0, 0, 0, 1, ST_QEMPTY));
        table_rows.push_back(row(0, '1, 16'hFFFF, 0, 1, ST_ADDED));
        table_rows.push_back(row(0, 0, 0, 32'hFFFF_FFFF, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h5, 1, 999, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h3, 2, 1, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'hAAAA_AAAA_AAAA, 16'h5555, 150_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h5555_5555_5555, 16'hAAAA, 150_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h10, 8, 0, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h10, 9, 0, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h7, 4, 60_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h2, 3, 1000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h1, 100, 2_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h8000_0000_0000, 7, 5_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h9, 16'h8000, 32'h8000_0000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h4, 12, 250_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h6, 6, 0, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h0000_0001_0000, 1, 300_000_000, 1, ST_ADDED));
        table_rows.push_back(row(0, 48'h77, 77, 77, 1, ST_FULL));
        repeat (6)
            table_rows.push_back(row(1, 0, 0, 0, 0, ST_DISPATCHED));
        foreach (table_rows[i])
            send(table_rows[i]);
        drain();

        // Random traffic at the reset settings, with a steady stretch and a pause
        // in which the sender waits for every outstanding result.
        random_run(15);
        steady = 1'b1;
        random_run(20);
        steady = 1'b0;
        while (expected_resp.size() != 0)
            @(posedge clk);
        random_run(15);
        drain();

        // All zero: the budget is zero so every dispatch of a non-empty queue is empty,
        // and the zero divisor acts as one. Index six and seven are unknown registers.
        set_all(0, 0, 0, 0, 0, 0);
        reg_write(6, 32'hFFFF_FFFF);
        reg_write(7, 32'h1234_5678);
        random_run(12);
        drain();

        // Largest values, written with bits above each register width set.
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFF00_0000, 32'hFFFF_FFFF);
        random_run(20);
        drain();

        // Cheap requests, a long slice and a unit divisor: large batches.
        set_all(1, 1, 1, 10_000_000, 0, 1);
        random_run(20);
        drain();

        // Allowance above the slice gives a negative budget.
        set_all(100, 100, 2, 1000, 5000, 7);
        random_run(8);
        drain();

        // Back to the defaults for a last stretch.
        set_all(SEEK_RST, ROTATION_RST, TRANSFER_RST, SLICE_RST, TRACK_RST, DIVISOR_RST);
        random_run(20);
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d adds and %0d dispatches over six register settings",
                 n_adds, n_dispatches);
        $display("checked %0d output transactions, %0d non-empty batches, %0d errors",
                 n_results, n_batches, errors);
        if (errors == 0 && expected_resp.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
